>>> rtl/buddy_block_allocator_core_defines.svh
// Assertion macros shared by the buddy block allocator RTL.
// Depends on nothing; included by the top level only.
`ifndef BUDDY_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define BBA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("buddy allocator assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define BBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("buddy allocator assertion failed");

`endif

>>> rtl/bba_pkg.sv
// Shared constants, types and helper functions of the buddy block allocator.
// Depends on nothing; used by bba_ctrl, bba_dpath and the top level.
`default_nettype none

package bba_pkg;

    localparam int BLOCK_BYTES  = 64;
    localparam int MAX_ORDER    = 4;
    localparam int NUM_CHUNKS   = 4;
    localparam int HEADER_BYTES = 40;

    localparam int CHUNK_BLOCKS = 1 << MAX_ORDER;
    localparam int TOTAL_BLOCKS = NUM_CHUNKS * CHUNK_BLOCKS;
    localparam int CHUNK_BYTES  = BLOCK_BYTES << MAX_ORDER;

    localparam int BYTES_W = 16;
    localparam int IDX_W   = 6;
    localparam int ORD_W   = 3;
    localparam int ST_W    = 3;
    localparam int SCAN_W  = IDX_W + 1;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 3'd0,
        ST_ZERO    = 3'd1,
        ST_BIG     = 3'd2,
        ST_NOMEM   = 3'd3,
        ST_BADFREE = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        RD_FREE  = 2'd0,
        RD_SCAN  = 2'd1,
        RD_BUDDY = 2'd2
    } t_rd_sel;

    // One entry of the block table.
    typedef struct packed {
        logic             head;
        logic             free;
        logic [ORD_W-1:0] order;
    } t_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    scan_next;
        logic    take;
        logic    split;
        logic    fin_wr;
        logic    fin_free;
        logic    free_take;
        logic    merge;
        logic    out_load;
        t_status out_st;
    } t_dp_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic    is_free_cmd;
        t_status pre_st;
        logic    scan_end;
        logic    scan_hit;
        logic    free_ok;
        logic    need_split;
        logic    ord_max;
        logic    can_merge;
        logic    out_busy;
    } t_dp_sts;

    // Contents of a table entry that has not been written since reset.
    function automatic t_entry reset_entry(input logic [IDX_W-1:0] idx);
        t_entry e;
        e.head  = (idx[MAX_ORDER-1:0] == '0);
        e.free  = 1'b1;
        e.order = e.head ? ORD_W'(MAX_ORDER) : '0;
        return e;
    endfunction

endpackage

`default_nettype wire

>>> rtl/bba_ctrl.sv
// Sequencing state machine of the buddy block allocator.
// Depends on bba_pkg; drives bba_dpath through command and status structs.
`default_nettype none

module bba_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire bba_pkg::t_dp_sts i_sts,
    output logic                  o_in_ready,
    output bba_pkg::t_dp_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PRE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SPLIT,
        S_FREE_CHK,
        S_MERGE_RD,
        S_MERGE_CHK,
        S_RESULT
    } t_state;

    t_state           r_state, n_state;
    bba_pkg::t_status r_st, n_st;

    always_comb begin
        n_state    = r_state;
        n_st       = r_st;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PRE;
                end
            end
            S_PRE: begin
                if (i_sts.is_free_cmd) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = bba_pkg::RD_FREE;
                    n_state      = S_FREE_CHK;
                end else if (i_sts.pre_st != bba_pkg::ST_OK) begin
                    n_st    = i_sts.pre_st;
                    n_state = S_RESULT;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                if (i_sts.scan_end) begin
                    n_st    = bba_pkg::ST_NOMEM;
                    n_state = S_RESULT;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = bba_pkg::RD_SCAN;
                    n_state      = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                if (i_sts.scan_hit) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_SPLIT;
                end else begin
                    o_cmd.scan_next = 1'b1;
                    n_state         = S_SCAN_RD;
                end
            end
            S_SPLIT: begin
                if (i_sts.need_split) begin
                    o_cmd.split = 1'b1;
                end else begin
                    o_cmd.fin_wr   = 1'b1;
                    o_cmd.fin_free = 1'b0;
                    n_st           = bba_pkg::ST_OK;
                    n_state        = S_RESULT;
                end
            end
            S_FREE_CHK: begin
                if (i_sts.free_ok) begin
                    o_cmd.free_take = 1'b1;
                    n_state         = S_MERGE_RD;
                end else begin
                    n_st    = bba_pkg::ST_BADFREE;
                    n_state = S_RESULT;
                end
            end
            S_MERGE_RD: begin
                if (i_sts.ord_max) begin
                    o_cmd.fin_wr   = 1'b1;
                    o_cmd.fin_free = 1'b1;
                    n_st           = bba_pkg::ST_OK;
                    n_state        = S_RESULT;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = bba_pkg::RD_BUDDY;
                    n_state      = S_MERGE_CHK;
                end
            end
            S_MERGE_CHK: begin
                if (i_sts.can_merge) begin
                    o_cmd.merge = 1'b1;
                    n_state     = S_MERGE_RD;
                end else begin
                    o_cmd.fin_wr   = 1'b1;
                    o_cmd.fin_free = 1'b1;
                    n_st           = bba_pkg::ST_OK;
                    n_state        = S_RESULT;
                end
            end
            S_RESULT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_st   = r_st;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_st    <= bba_pkg::ST_OK;
        end else begin
            r_state <= n_state;
            r_st    <= n_st;
        end
    end

endmodule

`default_nettype wire

>>> rtl/bba_dpath.sv
// Datapath of the buddy block allocator: block table, walk and merge registers,
// and the result register. Depends on bba_pkg; commanded by bba_ctrl.
`default_nettype none

module bba_dpath (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire bba_pkg::t_dp_cmd            i_cmd,
    input  wire logic                        i_in_cmd,
    input  wire logic [bba_pkg::BYTES_W-1:0] i_in_bytes,
    input  wire logic [bba_pkg::IDX_W-1:0]   i_in_index,
    input  wire logic                        i_out_ready,
    output bba_pkg::t_dp_sts                 o_sts,
    output logic                             o_out_valid,
    output logic [bba_pkg::ST_W-1:0]         o_out_status,
    output logic [bba_pkg::IDX_W-1:0]        o_out_index,
    output logic [bba_pkg::ORD_W-1:0]        o_out_order
);

    localparam int IDX_W  = bba_pkg::IDX_W;
    localparam int ORD_W  = bba_pkg::ORD_W;
    localparam int SCAN_W = bba_pkg::SCAN_W;
    localparam int NEED_W = bba_pkg::BYTES_W + 1;

    // Block table and its written-since-reset flags.
    bba_pkg::t_entry r_mem [bba_pkg::TOTAL_BLOCKS];
    logic            r_valid [bba_pkg::TOTAL_BLOCKS];

    bba_pkg::t_entry  r_rd_q;
    logic             r_rd_vld;
    logic [IDX_W-1:0] r_rd_addr;

    logic             r_is_free_cmd;
    bba_pkg::t_status r_pre_st;
    logic [ORD_W-1:0] r_req_ord;
    logic [IDX_W-1:0] r_free_idx;
    logic [SCAN_W-1:0] r_scan;
    logic [IDX_W-1:0] r_cur;
    logic [ORD_W-1:0] r_ord;

    logic             r_out_valid;
    bba_pkg::t_status r_out_st;
    logic [IDX_W-1:0] r_out_idx;
    logic [ORD_W-1:0] r_out_ord;

    logic [NEED_W-1:0] w_need;
    bba_pkg::t_status  w_pre;
    logic [ORD_W-1:0]  w_req_ord;
    bba_pkg::t_entry   w_rd;
    logic [IDX_W-1:0]  w_rd_addr;
    logic [IDX_W-1:0]  w_bit;
    logic [IDX_W-1:0]  w_buddy;
    logic [IDX_W-1:0]  w_hi;
    logic [IDX_W-1:0]  w_lo;
    logic [ORD_W-1:0]  w_split_ord;
    logic [IDX_W-1:0]  w_half;
    logic              w_wr_en;
    logic [IDX_W-1:0]  w_wr_addr;
    bba_pkg::t_entry   w_wr_data;

    // Size checks and required order of an allocate request.
    assign w_need = NEED_W'(i_in_bytes) + NEED_W'(bba_pkg::HEADER_BYTES);

    always_comb begin
        if (i_in_bytes == '0) begin
            w_pre = bba_pkg::ST_ZERO;
        end else if (i_in_bytes >
                     bba_pkg::BYTES_W'(bba_pkg::CHUNK_BYTES - bba_pkg::HEADER_BYTES)) begin
            w_pre = bba_pkg::ST_BIG;
        end else begin
            w_pre = bba_pkg::ST_OK;
        end
    end

    always_comb begin
        w_req_ord = ORD_W'(bba_pkg::MAX_ORDER);
        for (int o = bba_pkg::MAX_ORDER; o >= 0; o--) begin
            if (NEED_W'(bba_pkg::BLOCK_BYTES << o) >= w_need) begin
                w_req_ord = ORD_W'(o);
            end
        end
    end

    // Buddy arithmetic around the current head.
    assign w_bit       = IDX_W'(1) << r_ord;
    assign w_buddy     = r_cur ^ w_bit;
    assign w_hi        = r_cur | w_bit;
    assign w_lo        = r_cur & ~w_bit;
    assign w_split_ord = r_ord - ORD_W'(1);
    assign w_half      = r_cur + (IDX_W'(1) << w_split_ord);

    always_comb begin
        case (i_cmd.rd_sel)
            bba_pkg::RD_FREE:  w_rd_addr = r_free_idx;
            bba_pkg::RD_SCAN:  w_rd_addr = r_scan[IDX_W-1:0];
            bba_pkg::RD_BUDDY: w_rd_addr = w_buddy;
            default:           w_rd_addr = r_cur;
        endcase
    end

    assign w_rd = r_rd_vld ? r_rd_q : bba_pkg::reset_entry(r_rd_addr);

    // Single write port: split halves, merged-away buddies and the final head.
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_cur;
        w_wr_data = '0;
        if (i_cmd.split) begin
            w_wr_en         = 1'b1;
            w_wr_addr       = w_half;
            w_wr_data.head  = 1'b1;
            w_wr_data.free  = 1'b1;
            w_wr_data.order = w_split_ord;
        end else if (i_cmd.merge) begin
            w_wr_en         = 1'b1;
            w_wr_addr       = w_hi;
            w_wr_data.head  = 1'b0;
            w_wr_data.free  = 1'b1;
            w_wr_data.order = '0;
        end else if (i_cmd.fin_wr) begin
            w_wr_en         = 1'b1;
            w_wr_addr       = r_cur;
            w_wr_data.head  = 1'b1;
            w_wr_data.free  = i_cmd.fin_free;
            w_wr_data.order = r_ord;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_q    <= r_mem[w_rd_addr];
            r_rd_vld  <= r_valid[w_rd_addr];
            r_rd_addr <= w_rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < bba_pkg::TOTAL_BLOCKS; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else if (w_wr_en) begin
            r_valid[w_wr_addr] <= 1'b1;
        end
    end

    // Request, walk and merge registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_is_free_cmd <= (i_in_cmd == bba_pkg::CMD_FREE);
            r_pre_st      <= w_pre;
            r_req_ord     <= w_req_ord;
            r_free_idx    <= i_in_index;
            r_scan        <= '0;
        end
        if (i_cmd.scan_next) begin
            r_scan <= r_scan + (SCAN_W'(1) << w_rd.order);
        end
        if (i_cmd.take) begin
            r_cur <= r_scan[IDX_W-1:0];
            r_ord <= w_rd.order;
        end
        if (i_cmd.split) begin
            r_ord <= w_split_ord;
        end
        if (i_cmd.free_take) begin
            r_cur <= r_free_idx;
            r_ord <= w_rd.order;
        end
        if (i_cmd.merge) begin
            r_cur <= w_lo;
            r_ord <= r_ord + ORD_W'(1);
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_st  <= i_cmd.out_st;
            r_out_idx <= (i_cmd.out_st == bba_pkg::ST_OK) ? r_cur : '0;
            r_out_ord <= (i_cmd.out_st == bba_pkg::ST_OK) ? r_ord : '0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_st;
    assign o_out_index  = r_out_idx;
    assign o_out_order  = r_out_ord;

    always_comb begin
        o_sts             = '0;
        o_sts.is_free_cmd = r_is_free_cmd;
        o_sts.pre_st      = r_pre_st;
        o_sts.scan_end    = (r_scan >= SCAN_W'(bba_pkg::TOTAL_BLOCKS));
        o_sts.scan_hit    = w_rd.head && w_rd.free && (w_rd.order >= r_req_ord);
        o_sts.free_ok     = ({1'b0, r_free_idx} < SCAN_W'(bba_pkg::TOTAL_BLOCKS))
                            && w_rd.head && !w_rd.free;
        o_sts.need_split  = (r_ord > r_req_ord);
        o_sts.ord_max     = (r_ord >= ORD_W'(bba_pkg::MAX_ORDER));
        o_sts.can_merge   = w_rd.head && w_rd.free && (w_rd.order == r_ord);
        o_sts.out_busy    = r_out_valid && !i_out_ready;
    end

endmodule

`default_nettype wire

>>> rtl/buddy_block_allocator_core.sv
// Top level of the buddy block allocator: stream ports, controller and datapath.
// Depends on bba_pkg, bba_ctrl, bba_dpath and buddy_block_allocator_core_defines.svh.
`default_nettype none

`include "buddy_block_allocator_core_defines.svh"

// The allocator manages a pool of 4 chunks of 16 blocks of 64 bytes, 64 blocks in
// all, with the buddy scheme. An allocate request (tuser 0) carries a byte count;
// the block must also hold a 40-byte header, so the result is the smallest order
// from 0 to 4 whose region holds count plus header, taken from the first free
// head in address order and halved as needed. A free request (tuser 1) carries
// a block index, releases that allocated head and merges it with free buddies of
// equal order up to a whole chunk. Every request yields exactly one result
// transfer carrying a status and, on success, the block index and order; on any
// error the index and order read as zero. Requests are handled one at a time.
// An allocate visits block heads in address order, up to 64 of them, and then
// halves the found block as needed; a free reads its own head and then the
// buddy at each merge step. Each visited head and each merge step reads the
// block table through its single read port, whose read data is registered. The
// table needs no clearing pass after reset: per-entry valid flags make unwritten
// entries read as their reset contents. The next request is accepted while a
// finished result still waits in the output register.
module buddy_block_allocator_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // [15:0] req_bytes, [21:16] free_index, [23:22] zero
    input  wire logic        s_axis_tuser,   // [0] cmd
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata    // [2:0] status, [8:3] block_index,
                                             // [11:9] block_order, [15:12] zero
);

    bba_pkg::t_dp_cmd w_cmd;
    bba_pkg::t_dp_sts w_sts;

    logic [bba_pkg::ST_W-1:0]  w_out_status;
    logic [bba_pkg::IDX_W-1:0] w_out_index;
    logic [bba_pkg::ORD_W-1:0] w_out_order;

    bba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_sts      (w_sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    bba_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_in_cmd     (s_axis_tuser),
        .i_in_bytes   (s_axis_tdata[15:0]),
        .i_in_index   (s_axis_tdata[21:16]),
        .i_out_ready  (m_axis_tready),
        .o_sts        (w_sts),
        .o_out_valid  (m_axis_tvalid),
        .o_out_status (w_out_status),
        .o_out_index  (w_out_index),
        .o_out_order  (w_out_order)
    );

    assign m_axis_tdata = {4'b0000, w_out_order, w_out_index, w_out_status};

    // Once a request is taken, the block is not ready in the cycle after.
    `BBA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // A failed request never reports a block.
    `BBA_ASSERT_IMPL(a_error_no_block, i_clk, i_rst_n, m_axis_tvalid && (w_out_status != bba_pkg::ST_OK), (w_out_index == '0) && (w_out_order == '0))

    // A new result is never loaded over one that is still waiting.
    `BBA_ASSERT_IMPL(a_no_result_overwrite, i_clk, i_rst_n, w_cmd.out_load, !w_sts.out_busy)

    // The table write port has at most one user in any cycle.
    `BBA_ASSERT_IMPL(a_single_writer, i_clk, i_rst_n, 1'b1, $onehot0({w_cmd.split, w_cmd.merge, w_cmd.fin_wr}))

endmodule

`default_nettype wire
